@@ sv/ellr_pkg.sv @@
// Shared types and constants of the midpoint ellipse rasterizer.
// Used by the channel interfaces, the center queue, the stepping engine and the top level.
package ellr_pkg;

    localparam int MAX_SEMI_AXIS = 31;
    localparam int MAX_RESULTS   = 2 * MAX_SEMI_AXIS + 1;
    localparam int AXIS_W        = 5;
    localparam int CENTER_W      = 11;
    localparam int COORD_W       = 12;
    localparam int OFS_W         = 6;
    localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
    localparam int SQ_W          = 2 * AXIS_W;
    localparam int TERM_W        = 20;
    localparam int DEC_W         = 26;
    localparam int MOP_A_W       = 14;
    localparam int MOP_B_W       = 10;
    localparam int PROD_W        = MOP_A_W + MOP_B_W;
    localparam int K_W           = 15;

    localparam logic [AXIS_W-1:0] RESET_SEMI_AXIS_X = AXIS_W'(10);
    localparam logic [AXIS_W-1:0] RESET_SEMI_AXIS_Y = AXIS_W'(15);

    localparam logic REG_SEMI_AXIS_X = 1'b0;
    localparam logic REG_SEMI_AXIS_Y = 1'b1;

    typedef struct packed {
        logic [AXIS_W-1:0] a;
        logic [AXIS_W-1:0] b;
    } t_axes;

    typedef struct packed {
        logic signed [CENTER_W-1:0] x;
        logic signed [CENTER_W-1:0] y;
    } t_center;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_right;
        logic signed [COORD_W-1:0] x_left;
        logic signed [COORD_W-1:0] y_upper;
        logic signed [COORD_W-1:0] y_lower;
        logic                      last_step;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AA,
        ST_BB,
        ST_AAB,
        ST_AABB,
        ST_R1,
        ST_TX,
        ST_MBB,
        ST_TY,
        ST_MAA,
        ST_R2
    } t_state;

endpackage

@@ sv/ellr_in_if.sv @@
// Valid/ready channel that carries one ellipse center per transfer.
// Depends on ellr_pkg for the field widths.
interface ellr_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [ellr_pkg::CENTER_W-1:0] center_x;
    logic signed [ellr_pkg::CENTER_W-1:0] center_y;

    modport source(output valid, output center_x, output center_y, input ready);
    modport sink(input valid, input center_x, input center_y, output ready);
endinterface

@@ sv/ellr_out_if.sv @@
// Valid/ready channel that carries the four symmetric coordinates of one step.
// Depends on ellr_pkg for the field widths.
interface ellr_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [ellr_pkg::COORD_W-1:0] x_right;
    logic signed [ellr_pkg::COORD_W-1:0] x_left;
    logic signed [ellr_pkg::COORD_W-1:0] y_upper;
    logic signed [ellr_pkg::COORD_W-1:0] y_lower;
    logic                               last_step;

    modport source(output valid, output x_right, output x_left, output y_upper,
                   output y_lower, output last_step, input ready);
    modport sink(input valid, input x_right, input x_left, input y_upper,
                 input y_lower, input last_step, output ready);
endinterface

@@ sv/ellr_cfg.sv @@
// APB-style register file holding the two semi-axes.
// Depends on ellr_pkg.
module ellr_cfg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output ellr_pkg::t_axes       o_axes
);

    ellr_pkg::t_axes r_axes;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axes.a <= ellr_pkg::RESET_SEMI_AXIS_X;
            r_axes.b <= ellr_pkg::RESET_SEMI_AXIS_Y;
        end else if (wr_en) begin
            if (paddr[2] == ellr_pkg::REG_SEMI_AXIS_X) begin
                r_axes.a <= pwdata[ellr_pkg::AXIS_W-1:0];
            end else begin
                r_axes.b <= pwdata[ellr_pkg::AXIS_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == ellr_pkg::REG_SEMI_AXIS_X) begin
            prdata = 32'(r_axes.a);
        end else begin
            prdata = 32'(r_axes.b);
        end
    end

    assign o_axes = r_axes;

endmodule

@@ sv/ellr_queue.sv @@
// Two-entry queue of ellipse centers between the input channel and the engine.
// Depends on ellr_pkg and ellr_in_if.
module ellr_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ellr_in_if.sink    i_in,
    ellr_in_if.source  o_out
);

    ellr_pkg::t_center r_mem [2];
    logic              r_wptr;
    logic              r_rptr;
    logic [1:0]        r_count;
    logic              push;
    logic              pop;

    assign i_in.ready  = (r_count != 2'd2);
    assign o_out.valid = (r_count != 2'd0);
    assign push        = i_in.valid && i_in.ready;
    assign pop         = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr].x <= i_in.center_x;
            r_mem[r_wptr].y <= i_in.center_y;
        end
    end

    assign o_out.center_x = r_mem[r_rptr].x;
    assign o_out.center_y = r_mem[r_rptr].y;

endmodule

@@ sv/ellr_engine.sv @@
// Stepping engine: setup through one shared multiplier, then both regions of the trace.
// Depends on ellr_pkg, ellr_in_if and ellr_out_if.
module ellr_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ellr_pkg::t_axes  i_axes,
    ellr_in_if.sink          i_in,
    ellr_out_if.source       o_out
);

    localparam int DW = ellr_pkg::DEC_W;
    localparam int TW = ellr_pkg::TERM_W;
    localparam int OW = ellr_pkg::OFS_W;
    localparam int SW = ellr_pkg::SQ_W;
    localparam int KW = ellr_pkg::K_W;
    localparam int CW = ellr_pkg::CNT_W;

    ellr_pkg::t_state  r_state, n_state;
    ellr_pkg::t_center r_ctr, n_ctr;
    ellr_pkg::t_result r_out, n_out;
    logic              r_out_valid, n_out_valid;
    logic [OW-1:0]     r_x, n_x;
    logic [OW-1:0]     r_y, n_y;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [DW-1:0]     r_d, n_d;
    logic [TW-1:0]     r_t1, n_t1;
    logic [TW-1:0]     r_t2, n_t2;
    logic [SW-1:0]     r_aa, n_aa;
    logic [SW-1:0]     r_bb, n_bb;
    logic [KW-1:0]     r_k1, n_k1;
    logic [KW-1:0]     r_k2, n_k2;
    logic [KW-1:0]     r_bb12, n_bb12;
    logic [KW-1:0]     r_aa12, n_aa12;
    logic [DW-1:0]     r_aabb4, n_aabb4;
    logic [ellr_pkg::MOP_A_W-1:0] r_m, n_m;
    logic [ellr_pkg::PROD_W-1:0]  r_acc, n_acc;

    logic [ellr_pkg::MOP_A_W-1:0] mul_a;
    logic [ellr_pkg::MOP_B_W-1:0] mul_b;
    logic [ellr_pkg::PROD_W-1:0]  prod;
    logic                         slot_free;
    logic                         last;
    logic [OW-1:0]                ty;
    logic [ellr_pkg::COORD_W-1:0] cx, cy, ox, oy;

    assign prod      = ellr_pkg::PROD_W'(mul_a) * ellr_pkg::PROD_W'(mul_b);
    assign slot_free = !r_out_valid || o_out.ready;
    assign ty        = (r_y == '0) ? OW'(1) : r_y - OW'(1);
    assign cx        = {r_ctr.x[ellr_pkg::CENTER_W-1], r_ctr.x};
    assign cy        = {r_ctr.y[ellr_pkg::CENTER_W-1], r_ctr.y};
    assign ox        = ellr_pkg::COORD_W'(r_x);
    assign oy        = ellr_pkg::COORD_W'(r_y);

    always_comb begin
        n_state     = r_state;
        n_ctr       = r_ctr;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_x         = r_x;
        n_y         = r_y;
        n_cnt       = r_cnt;
        n_d         = r_d;
        n_t1        = r_t1;
        n_t2        = r_t2;
        n_aa        = r_aa;
        n_bb        = r_bb;
        n_k1        = r_k1;
        n_k2        = r_k2;
        n_bb12      = r_bb12;
        n_aa12      = r_aa12;
        n_aabb4     = r_aabb4;
        n_m         = r_m;
        n_acc       = r_acc;
        mul_a       = '0;
        mul_b       = '0;
        last        = 1'b0;
        i_in.ready  = 1'b0;

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ellr_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_ctr.x = i_in.center_x;
                    n_ctr.y = i_in.center_y;
                    n_x     = '0;
                    n_y     = OW'(i_axes.b);
                    n_cnt   = '0;
                    n_t1    = '0;
                    n_state = ellr_pkg::ST_AA;
                end
            end
            ellr_pkg::ST_AA: begin
                mul_a   = ellr_pkg::MOP_A_W'(i_axes.a);
                mul_b   = ellr_pkg::MOP_B_W'(i_axes.a);
                n_aa    = prod[SW-1:0];
                n_state = ellr_pkg::ST_BB;
            end
            ellr_pkg::ST_BB: begin
                mul_a   = ellr_pkg::MOP_A_W'(i_axes.b);
                mul_b   = ellr_pkg::MOP_B_W'(i_axes.b);
                n_bb    = prod[SW-1:0];
                n_state = ellr_pkg::ST_AAB;
            end
            ellr_pkg::ST_AAB: begin
                mul_a   = ellr_pkg::MOP_A_W'(r_aa);
                mul_b   = ellr_pkg::MOP_B_W'(i_axes.b);
                n_d     = DW'({r_bb, 2'b00}) + DW'(r_aa) - DW'({prod, 2'b00});
                n_t2    = TW'({prod, 3'b000});
                n_state = ellr_pkg::ST_AABB;
            end
            ellr_pkg::ST_AABB: begin
                mul_a   = ellr_pkg::MOP_A_W'(r_aa);
                mul_b   = ellr_pkg::MOP_B_W'(r_bb);
                n_aabb4 = DW'({prod, 2'b00});
                n_bb12  = KW'({r_bb, 3'b000}) + KW'({r_bb, 2'b00});
                n_aa12  = KW'({r_aa, 3'b000}) + KW'({r_aa, 2'b00});
                n_k1    = KW'({r_bb, 3'b000}) + KW'({r_bb, 2'b00}) + KW'({r_aa, 3'b000});
                n_k2    = KW'({r_bb, 3'b000}) + KW'({r_aa, 3'b000}) + KW'({r_aa, 2'b00});
                n_state = ellr_pkg::ST_R1;
            end
            ellr_pkg::ST_R1: begin
                if (r_t1 < r_t2) begin
                    if (slot_free) begin
                        last              = (r_cnt == CW'(ellr_pkg::MAX_RESULTS - 1));
                        n_out_valid       = 1'b1;
                        n_out.x_right     = cx + ox;
                        n_out.x_left      = cx - ox;
                        n_out.y_upper     = cy + oy;
                        n_out.y_lower     = cy - oy;
                        n_out.last_step   = last;
                        n_cnt             = r_cnt + CW'(1);
                        if (r_d[DW-1]) begin
                            n_d = r_d + DW'(r_t1) + DW'(r_bb12);
                        end else begin
                            n_d  = r_d + DW'(r_t1) + DW'(r_k1) - DW'(r_t2);
                            n_y  = r_y - OW'(1);
                            n_t2 = r_t2 - TW'({r_aa, 3'b000});
                        end
                        n_x  = r_x + OW'(1);
                        n_t1 = r_t1 + TW'({r_bb, 3'b000});
                        if (last) begin
                            n_state = ellr_pkg::ST_IDLE;
                        end
                    end
                end else begin
                    n_state = ellr_pkg::ST_TX;
                end
            end
            ellr_pkg::ST_TX: begin
                mul_a   = ellr_pkg::MOP_A_W'({r_x, 1'b1});
                mul_b   = ellr_pkg::MOP_B_W'({r_x, 1'b1});
                n_m     = prod[ellr_pkg::MOP_A_W-1:0];
                n_state = ellr_pkg::ST_MBB;
            end
            ellr_pkg::ST_MBB: begin
                mul_a   = r_m;
                mul_b   = ellr_pkg::MOP_B_W'(r_bb);
                n_acc   = prod;
                n_state = ellr_pkg::ST_TY;
            end
            ellr_pkg::ST_TY: begin
                mul_a   = ellr_pkg::MOP_A_W'(ty);
                mul_b   = ellr_pkg::MOP_B_W'(ty);
                n_m     = prod[ellr_pkg::MOP_A_W-1:0];
                n_state = ellr_pkg::ST_MAA;
            end
            ellr_pkg::ST_MAA: begin
                mul_a   = r_m;
                mul_b   = ellr_pkg::MOP_B_W'(r_aa);
                n_d     = DW'(r_acc) + DW'({prod, 2'b00}) - r_aabb4;
                n_state = ellr_pkg::ST_R2;
            end
            ellr_pkg::ST_R2: begin
                if (slot_free) begin
                    last            = (r_y == '0) ||
                                      (r_cnt == CW'(ellr_pkg::MAX_RESULTS - 1));
                    n_out_valid     = 1'b1;
                    n_out.x_right   = cx + ox;
                    n_out.x_left    = cx - ox;
                    n_out.y_upper   = cy + oy;
                    n_out.y_lower   = cy - oy;
                    n_out.last_step = last;
                    n_cnt           = r_cnt + CW'(1);
                    if (r_d[DW-1]) begin
                        n_d  = r_d + DW'(r_t1) + DW'(r_k2) - DW'(r_t2);
                        n_x  = r_x + OW'(1);
                        n_t1 = r_t1 + TW'({r_bb, 3'b000});
                    end else begin
                        n_d = r_d + DW'(r_aa12) - DW'(r_t2);
                    end
                    n_y  = r_y - OW'(1);
                    n_t2 = r_t2 - TW'({r_aa, 3'b000});
                    if (last) begin
                        n_state = ellr_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ellr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ellr_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctr   <= n_ctr;
        r_out   <= n_out;
        r_x     <= n_x;
        r_y     <= n_y;
        r_cnt   <= n_cnt;
        r_d     <= n_d;
        r_t1    <= n_t1;
        r_t2    <= n_t2;
        r_aa    <= n_aa;
        r_bb    <= n_bb;
        r_k1    <= n_k1;
        r_k2    <= n_k2;
        r_bb12  <= n_bb12;
        r_aa12  <= n_aa12;
        r_aabb4 <= n_aabb4;
        r_m     <= n_m;
        r_acc   <= n_acc;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.x_right   = r_out.x_right;
    assign o_out.x_left    = r_out.x_left;
    assign o_out.y_upper   = r_out.y_upper;
    assign o_out.y_lower   = r_out.y_lower;
    assign o_out.last_step = r_out.last_step;

endmodule

@@ sv/ellipse_rasterizer.sv @@
// Midpoint ellipse rasterizer: one result per step, four symmetric points each.
// Each result is registered; the stepping sequencer takes a new center only when idle, after
// the last result of the previous ellipse, and it stalls while its output holds an untaken
// result. Its shared multiplier serves the setup steps.
// Reset: semi-axes return to 10 and 15, the center queue empties, the engine goes idle.
// Depends on ellr_pkg, ellr_in_if, ellr_out_if, ellr_cfg, ellr_queue and ellr_engine.
module ellipse_rasterizer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ellr_in_if.sink       i_item,
    ellr_out_if.source    o_result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    ellr_pkg::t_axes axes;
    ellr_in_if       q_if();

    ellr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_axes  (axes)
    );

    ellr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_item),
        .o_out   (q_if.source)
    );

    ellr_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_axes  (axes),
        .i_in    (q_if.sink),
        .o_out   (o_result)
    );

endmodule
